// File: sv/clamp_point_to_circle_core_assert.svh
// assertion macros for the clamp-to-circle block
// used by the port checker; needs clock and reset in scope
`ifndef CLAMP_POINT_TO_CIRCLE_CORE_ASSERT_SVH
`define CLAMP_POINT_TO_CIRCLE_CORE_ASSERT_SVH

// checked only outside reset
`define CPC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked also across reset
`define CPC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: sv/cpc_pkg.sv
`timescale 1ns / 1ps
// types and register codes for the clamp-to-circle block
// no dependencies
package cpc_pkg;

   localparam logic [1:0] REG_CENTER_X = 2'd0;
   localparam logic [1:0] REG_CENTER_Y = 2'd1;
   localparam logic [1:0] REG_RADIUS   = 2'd2;

   localparam int SQRT_STEPS = 33;
   localparam int DIV_STEPS  = 33;
   // in, offset, square, sum, sqrt steps, product, divide steps
   localparam int NUM_STAGES = 4 + SQRT_STEPS + 1 + DIV_STEPS;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic               was_clamped;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic        negx;
      logic        negy;
      logic [32:0] magx;
      logic [32:0] magy;
      logic [65:0] s;
      logic        clamp;
      logic [35:0] srem;
      logic [32:0] root;
      logic [63:0] nx;
      logic [63:0] ny;
      logic [33:0] remx;
      logic [33:0] remy;
      logic [32:0] qx;
      logic [32:0] qy;
   } pipe_type;

endpackage

// File: sv/clamp_point_to_circle_core.sv
`timescale 1ns / 1ps
// clamp-to-circle top level: config registers, pipeline, output buffer
// depends on cpc_pkg
// A point (signed Q16.16) goes in and is carried through the pipeline; a new
// request is taken every cycle while req_stall is low. Most of the pipeline is
// the bit-per-stage square root (33 stages) and the bit-per-stage dividers
// (33 stages, x and y side by side). A two-entry output buffer lets requests keep
// flowing while a result waits; req_stall rises only when both entries are full.
// Points with dx^2+dy^2 below radius^2 pass unchanged, others are pulled onto the
// circle with truncating division and 32-bit saturation. Configuration: 0x0
// center x, 0x4 center y, 0x8 radius (31 bits); write only while no request is
// in flight.
module clamp_point_to_circle_core
   import cpc_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [30:0] RAD_RST = 31'(64'd1 << FRAC_BITS);
   localparam logic [61:0] R2_RST  = 62'(RAD_RST) * 62'(RAD_RST);

   // configuration registers
   logic signed [31:0] cx_ff, cy_ff;
   logic [30:0]        rad_ff;
   logic [61:0]        r2_ff;
   logic               wr_en;
   logic [1:0]         wr_idx;

   assign csr_pready = 1'b1;
   assign wr_en  = csr_psel && csr_penable && csr_pwrite;
   assign wr_idx = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff  <= '0;
         cy_ff  <= '0;
         rad_ff <= RAD_RST;
         r2_ff  <= R2_RST;
      end else if (wr_en) begin
         unique case (wr_idx)
            REG_CENTER_X: cx_ff <= csr_pwdata;
            REG_CENTER_Y: cy_ff <= csr_pwdata;
            REG_RADIUS: begin
               rad_ff <= csr_pwdata[30:0];
               // radius squared kept ready for the compare
               r2_ff  <= 62'(csr_pwdata[30:0]) * 62'(csr_pwdata[30:0]);
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (wr_idx)
         REG_CENTER_X: csr_prdata = cx_ff;
         REG_CENTER_Y: csr_prdata = cy_ff;
         REG_RADIUS:   csr_prdata = {1'b0, rad_ff};
         default:      csr_prdata = '0;
      endcase
   end

   // pipeline: whole pipe moves when the output buffer has room
   pipe_type st_ff [NUM_STAGES];
   pipe_type st_in [NUM_STAGES];
   logic [NUM_STAGES-1:0] vld_ff;
   logic [1:0] cnt_ff;
   logic       adv;

   assign adv       = (cnt_ff != 2'd2);
   assign req_stall = !adv;

   // stage 0: capture the request
   always_comb begin
      st_in[0]    = '0;
      st_in[0].px = req_data.point_x;
      st_in[0].py = req_data.point_y;
   end

   // stage 1: offsets from center, sign and magnitude
   always_comb begin
      logic [32:0] dx, dy;
      dx = {st_ff[0].px[31], st_ff[0].px} - {cx_ff[31], cx_ff};
      dy = {st_ff[0].py[31], st_ff[0].py} - {cy_ff[31], cy_ff};
      st_in[1]      = st_ff[0];
      st_in[1].negx = dx[32];
      st_in[1].negy = dy[32];
      st_in[1].magx = dx[32] ? -dx : dx;
      st_in[1].magy = dy[32] ? -dy : dy;
   end

   // stage 2: low-part squares (a magnitude of 2^32 has zero low bits)
   always_comb begin
      st_in[2]    = st_ff[1];
      st_in[2].nx = 64'(st_ff[1].magx[31:0]) * 64'(st_ff[1].magx[31:0]);
      st_in[2].ny = 64'(st_ff[1].magy[31:0]) * 64'(st_ff[1].magy[31:0]);
   end

   // stage 3: sum of squares, sqrt state cleared
   always_comb begin
      logic [65:0] sx, sy;
      sx = st_ff[2].magx[32] ? (66'd1 << 64) : 66'(st_ff[2].nx);
      sy = st_ff[2].magy[32] ? (66'd1 << 64) : 66'(st_ff[2].ny);
      st_in[3]      = st_ff[2];
      st_in[3].s    = sx + sy;
      st_in[3].srem = '0;
      st_in[3].root = '0;
   end

   // square root, one result bit per stage; first stage also does the compare
   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      localparam int BI = SQRT_STEPS - 1 - j;
      always_comb begin
         logic [35:0] rem_sh, trial;
         rem_sh = {st_ff[3+j].srem[33:0], st_ff[3+j].s[2*BI+1 -: 2]};
         trial  = {1'b0, st_ff[3+j].root, 2'b01};
         st_in[4+j] = st_ff[3+j];
         if (j == 0) begin
            st_in[4+j].clamp = (st_ff[3+j].s >= 66'(r2_ff));
         end
         if (rem_sh >= trial) begin
            st_in[4+j].srem = rem_sh - trial;
            st_in[4+j].root = {st_ff[3+j].root[31:0], 1'b1};
         end else begin
            st_in[4+j].srem = rem_sh;
            st_in[4+j].root = {st_ff[3+j].root[31:0], 1'b0};
         end
      end
   end

   localparam int MUL_ST = 4 + SQRT_STEPS;

   // numerators |d| * radius, divider remainders seeded
   always_comb begin
      logic [62:0] px_prod, py_prod;
      logic [63:0] nx, ny;
      px_prod = 63'(st_ff[MUL_ST-1].magx[31:0]) * 63'(rad_ff);
      py_prod = 63'(st_ff[MUL_ST-1].magy[31:0]) * 63'(rad_ff);
      nx = st_ff[MUL_ST-1].magx[32] ? {1'b0, rad_ff, 32'd0} : {1'b0, px_prod};
      ny = st_ff[MUL_ST-1].magy[32] ? {1'b0, rad_ff, 32'd0} : {1'b0, py_prod};
      st_in[MUL_ST]      = st_ff[MUL_ST-1];
      st_in[MUL_ST].nx   = nx;
      st_in[MUL_ST].ny   = ny;
      st_in[MUL_ST].remx = {3'd0, nx[63:33]};
      st_in[MUL_ST].remy = {3'd0, ny[63:33]};
      st_in[MUL_ST].qx   = '0;
      st_in[MUL_ST].qy   = '0;
   end

   // restoring division by the root, one quotient bit per stage
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      localparam int BI = DIV_STEPS - 1 - j;
      localparam int K  = MUL_ST + 1 + j;
      always_comb begin
         logic [33:0] rx, ry, dv;
         rx = {st_ff[K-1].remx[32:0], st_ff[K-1].nx[BI]};
         ry = {st_ff[K-1].remy[32:0], st_ff[K-1].ny[BI]};
         dv = {1'b0, st_ff[K-1].root};
         st_in[K] = st_ff[K-1];
         if (rx >= dv) begin
            st_in[K].remx = rx - dv;
            st_in[K].qx   = {st_ff[K-1].qx[31:0], 1'b1};
         end else begin
            st_in[K].remx = rx;
            st_in[K].qx   = {st_ff[K-1].qx[31:0], 1'b0};
         end
         if (ry >= dv) begin
            st_in[K].remy = ry - dv;
            st_in[K].qy   = {st_ff[K-1].qy[31:0], 1'b1};
         end else begin
            st_in[K].remy = ry;
            st_in[K].qy   = {st_ff[K-1].qy[31:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NUM_STAGES-2:0], req_valid};
      end
   end

   for (genvar k = 0; k < NUM_STAGES; k++) begin : g_regs
      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   // final: signed add to center, saturate, pick pass-through or center
   pipe_type lst;
   rsp_type  fin;
   logic signed [34:0] sumx, sumy;

   assign lst = st_ff[NUM_STAGES-1];

   function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
      logic signed [31:0] r;
      if (v > 35'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -35'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   always_comb begin
      sumx = lst.negx ? (35'(cx_ff) - $signed({2'b00, lst.qx}))
                      : (35'(cx_ff) + $signed({2'b00, lst.qx}));
      sumy = lst.negy ? (35'(cy_ff) - $signed({2'b00, lst.qy}))
                      : (35'(cy_ff) + $signed({2'b00, lst.qy}));
      fin.was_clamped = lst.clamp;
      if (!lst.clamp) begin
         fin.out_x = lst.px;
         fin.out_y = lst.py;
      end else if (lst.root == '0) begin
         fin.out_x = cx_ff;
         fin.out_y = cy_ff;
      end else begin
         fin.out_x = sat32(sumx);
         fin.out_y = sat32(sumy);
      end
   end

   // two-entry output buffer, head in ob0
   rsp_type ob0_ff, ob1_ff;
   logic    push, pop;

   assign push = adv && vld_ff[NUM_STAGES-1];
   assign pop  = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (cnt_ff == 2'd2) begin
            ob0_ff <= ob1_ff;
         end else if (push) begin
            ob0_ff <= fin;
         end
      end else if (push) begin
         if (cnt_ff == 2'd0) begin
            ob0_ff <= fin;
         end else begin
            ob1_ff <= fin;
         end
      end
   end

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = ob0_ff;

endmodule

// File: sv/cpc_checker.sv
`timescale 1ns / 1ps
// port checker for the clamp-to-circle block, bound to the top level
// depends on cpc_pkg and the assertion macro header
`include "clamp_point_to_circle_core_assert.svh"

module cpc_checker
   import cpc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data,
   input logic    csr_pready
);

   `CPC_ASSERT_ALWAYS(a_empty_after_reset, $past(reset) && !reset |-> !rsp_valid, "result after reset")
   `CPC_ASSERT(a_stall_needs_result, req_stall |-> rsp_valid, "request stalled with no result")
   `CPC_ASSERT(a_pready_high, csr_pready, "pready low")
   `CPC_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "result dropped")

endmodule

bind clamp_point_to_circle_core cpc_checker u_cpc_checker (
   .clock(clock),
   .reset(reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data(rsp_data),
   .csr_pready(csr_pready)
);

// File: bench/tb.sv
`timescale 1ns / 1ps
// self-checking bench for clamp_point_to_circle_core: directed table, then random points
// depends on cpc_pkg and the block's rtl
module tb;
   import cpc_pkg::*;

   // pipeline depth, matching NUM_STAGES in cpc_pkg, used for settle waits
   localparam int LATENCY = 71;
   localparam int CYCLE_LIMIT = 400000;
   localparam int N_RANDOM = 640;
   localparam int N_PRESSURE = 160;
   localparam int HOLD_CYCLES = 600;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   clamp_point_to_circle_core DUT (.*);

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // bench copy of the configuration registers
   logic signed [31:0] cfg_cx;
   logic signed [31:0] cfg_cy;
   logic [30:0]        cfg_radius;

   rsp_type expected_q[$];
   int      error_count = 0;
   int      rsp_count = 0;
   int      clamped_count = 0;
   int      cycle_count = 0;
   bit      stall_hold = 1'b0;   // forces a long receiver hold-off
   bit      hold_go = 1'b0;
   bit      rsp_random = 1'b0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s: got %h want %h (result %0d)", what, got, want, rsp_count);
      error_count++;
   endtask

   // scale one axis: center + d*r/root, truncated toward zero, saturated
   function automatic logic [31:0] pull_axis(input logic signed [31:0] c,
                                             input logic signed [32:0] d,
                                             input logic [33:0] root_d);
      logic [32:0]        mag;
      logic [64:0]        q;
      logic signed [66:0] v;
      mag = d[32] ? 33'(-d) : 33'(d);
      q   = ({32'd0, mag} * {34'd0, cfg_radius}) / root_d;
      v   = d[32] ? -$signed({2'b00, q}) : $signed({2'b00, q});
      v   = v + c;
      if (v > 67'sd2147483647) return 32'h7fffffff;
      if (v < -67'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   function automatic rsp_type clamp_to_circle(input req_type p);
      rsp_type            r;
      logic signed [32:0] dx, dy;
      logic [32:0]        ax, ay;
      logic [66:0]        dsq;
      logic [66:0]        rsq;
      logic [33:0]        root, trial;
      dx  = 33'(p.point_x) - 33'(cfg_cx);
      dy  = 33'(p.point_y) - 33'(cfg_cy);
      ax  = dx[32] ? 33'(-dx) : 33'(dx);
      ay  = dy[32] ? 33'(-dy) : 33'(dy);
      dsq = 67'(ax) * 67'(ax) + 67'(ay) * 67'(ay);
      rsq = 67'(cfg_radius) * 67'(cfg_radius);
      if (dsq < rsq) begin
         r.out_x = p.point_x;
         r.out_y = p.point_y;
         r.was_clamped = 1'b0;
         return r;
      end
      root = '0;
      for (int b = 33; b >= 0; b--) begin
         trial = root | (34'd1 << b);
         if (68'(trial) * 68'(trial) <= 68'(dsq)) root = trial;
      end
      r.was_clamped = 1'b1;
      if (root == 0) begin
         r.out_x = cfg_cx;
         r.out_y = cfg_cy;
      end else begin
         r.out_x = pull_axis(cfg_cx, dx, root);
         r.out_y = pull_axis(cfg_cy, dy, root);
      end
      return r;
   endfunction

   // write in two phases: setup then access
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_CENTER_X: cfg_cx = value;
         REG_CENTER_Y: cfg_cy = value;
         REG_RADIUS:   cfg_radius = value[30:0];
         default: ;
      endcase
   endtask

   task automatic set_circle(input logic [31:0] cx, input logic [31:0] cy,
                             input logic [31:0] r);
      csr_write(REG_CENTER_X, cx);
      csr_write(REG_CENTER_Y, cy);
      csr_write(REG_RADIUS, r);
   endtask

   // wait for every expected result, then let the pipe settle
   task automatic drain;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   function automatic int gap_len;
      int k;
      k = $urandom_range(0, 99);
      if (k < 55) return 0;
      if (k < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // offer one request, hold it until accepted
   task automatic send_point(input req_type p, input rsp_type want);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (req_stall);
      expected_q.push_back(want);
   endtask

   task automatic end_burst;
      req_valid <= 1'b0;
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $display("result %0d arrived with nothing expected", rsp_count);
            error_count++;
         end else begin
            rsp_type want;
            want = expected_q.pop_front();
            if (rsp_data.out_x !== want.out_x)
               report_mismatch("out_x", rsp_data.out_x, want.out_x);
            if (rsp_data.out_y !== want.out_y)
               report_mismatch("out_y", rsp_data.out_y, want.out_y);
            if (rsp_data.was_clamped !== want.was_clamped)
               report_mismatch("was_clamped", 32'(rsp_data.was_clamped),
                               32'(want.was_clamped));
            if (want.was_clamped) clamped_count++;
         end
         rsp_count++;
      end
   end

   // receiver stall pattern: random gaps when enabled, or a forced hold-off
   always @(posedge clock) begin
      int k;
      if (stall_hold) rsp_stall <= 1'b1;
      else if (!rsp_random) rsp_stall <= 1'b0;
      else begin
         k = $urandom_range(0, 99);
         if (rsp_stall) rsp_stall <= (k < 60);
         else rsp_stall <= (k < 20);
      end
   end

   // long hold-off counted in cycles so the pipe backs up into req_stall
   initial begin
      wait (hold_go);
      @(posedge clock);
      stall_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      stall_hold <= 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // directed rows: point, and a typed expectation where it is obvious
   typedef struct {
      logic [31:0] px;
      logic [31:0] py;
      bit          known;
      logic [31:0] ex;
      logic [31:0] ey;
      bit          ec;
   } row_type;

   row_type directed[$];

   task automatic add_row(input logic [31:0] px, input logic [31:0] py, input bit known,
                          input logic [31:0] ex, input logic [31:0] ey, input bit ec);
      row_type r;
      r.px = px; r.py = py; r.known = known; r.ex = ex; r.ey = ey; r.ec = ec;
      directed.push_back(r);
   endtask

   task automatic run_directed;
      req_type p;
      rsp_type w;
      foreach (directed[i]) begin
         p.point_x = directed[i].px;
         p.point_y = directed[i].py;
         if (directed[i].known) begin
            w.out_x = directed[i].ex;
            w.out_y = directed[i].ey;
            w.was_clamped = directed[i].ec;
         end else begin
            w = clamp_to_circle(p);
         end
         send_point(p, w);
      end
      end_burst();
      directed.delete();
   endtask

   function automatic logic [31:0] rand_near(input logic [31:0] c, input logic [30:0] r);
      int k;
      k = $urandom_range(0, 3);
      if (k == 0) return $urandom;
      // offsets around the radius so both branches show up
      return 32'(c + $signed(33'($urandom_range(0, 2 * r + 16))) - $signed(33'(r + 8)));
   endfunction

   initial begin
      req_type p;
      int      burst;
      cfg_cx = 0;
      cfg_cy = 0;
      cfg_radius = 31'd65536;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset circle: unit radius about the origin
      add_row(32'h0, 32'h0, 1, 32'h0, 32'h0, 0);
      add_row(32'h8000, 32'h0, 1, 32'h8000, 32'h0, 0);
      // exactly on the circle counts as clamped
      add_row(32'h10000, 32'h0, 1, 32'h10000, 32'h0, 1);
      add_row(32'h0, 32'hffff0000, 1, 32'h0, 32'hffff0000, 1);
      add_row(32'h20000, 32'h0, 1, 32'h10000, 32'h0, 1);
      add_row(32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0);
      add_row(32'h80000000, 32'h80000000, 0, 0, 0, 0);
      add_row(32'h7fffffff, 32'h80000000, 0, 0, 0, 0);
      add_row(32'h30000, 32'h40000, 0, 0, 0, 0);
      run_directed();
      drain();

      // zero radius: the center itself gives zero distance
      set_circle(32'h00050000, 32'hfffb0000, 32'h0);
      add_row(32'h00050000, 32'hfffb0000, 1, 32'h00050000, 32'hfffb0000, 1);
      add_row(32'h00060000, 32'hfffb0000, 1, 32'h00050000, 32'hfffb0000, 1);
      add_row(32'h80000000, 32'h7fffffff, 0, 0, 0, 0);
      run_directed();
      drain();

      // extreme center and full radius
      set_circle(32'h7fffffff, 32'h80000000, 32'h7fffffff);
      add_row(32'h80000000, 32'h7fffffff, 0, 0, 0, 0);
      add_row(32'h7fffffff, 32'h80000000, 1, 32'h7fffffff, 32'h80000000, 0);
      add_row(32'h80000000, 32'h80000000, 0, 0, 0, 0);
      add_row(32'h00000000, 32'h00000000, 0, 0, 0, 0);
      run_directed();
      drain();

      set_circle(32'h80000000, 32'h7fffffff, 32'h7fffffff);
      add_row(32'h7fffffff, 32'h80000000, 0, 0, 0, 0);
      add_row(32'h12345678, 32'hedcba987, 0, 0, 0, 0);
      run_directed();
      drain();

      // receiver held off for a long stretch while requests keep coming
      set_circle(32'h0, 32'h0, 32'h00100000);
      hold_go = 1'b1;
      for (int i = 0; i < N_PRESSURE; i++) begin
         p.point_x = rand_near(cfg_cx, cfg_radius);
         p.point_y = rand_near(cfg_cy, cfg_radius);
         send_point(p, clamp_to_circle(p));
      end
      end_burst();
      drain();

      // random phases over several circles, receiver stalls on
      rsp_random = 1'b1;
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: set_circle($urandom, $urandom, $urandom_range(0, 32'h7fffffff));
            1: set_circle($urandom_range(0, 32'h000fffff) - 32'h00080000,
                          $urandom_range(0, 32'h000fffff) - 32'h00080000,
                          $urandom_range(1, 32'h00040000));
            2: set_circle($urandom, $urandom, $urandom_range(0, 4));
            default: set_circle(32'h0, 32'h0, 32'h00010000 << $urandom_range(0, 14));
         endcase
         burst = N_RANDOM / 8;
         for (int i = 0; i < burst; i++) begin
            p.point_x = rand_near(cfg_cx, cfg_radius);
            p.point_y = rand_near(cfg_cy, cfg_radius);
            send_point(p, clamp_to_circle(p));
         end
         end_burst();
         drain();
      end
      rsp_random = 1'b0;

      $display("covered %0d results, %0d of them pulled onto the circle", rsp_count,
               clamped_count);
      $display("config phases included reset, zero radius, extreme centers and a long hold-off");
      if (error_count == 0 && expected_q.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
